FILE: sv/u8je_pkg.sv
// Shared types, constants and helper functions of the UTF-8 to JSON escaper.
package u8je_pkg;

  localparam int CountWidth = 25;
  localparam int CfgWidth = 25;
  localparam int CmpWidth = ((CountWidth > CfgWidth) ? CountWidth : CfgWidth) + 1;
  localparam logic [CfgWidth-1:0] LimitReset = CfgWidth'(25'd16777216);

  localparam int MaxResults = 14;
  localparam int StepWidth = $clog2(MaxResults);

  localparam int QueueDepth = 4;
  localparam int QueuePtrWidth = $clog2(QueueDepth);

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusInvalid = 2'd1;
  localparam logic [1:0] StatusLimit = 2'd2;

  localparam logic [6:0] CharQuote = 7'h22;
  localparam logic [6:0] CharBackslash = 7'h5c;
  localparam logic [6:0] CharU = 7'h75;
  localparam logic [6:0] CharNul = 7'h00;

  localparam logic [7:0] Lead2Low = 8'hc2;
  localparam logic [7:0] Lead2High = 8'hdf;
  localparam logic [7:0] Lead3Low = 8'he0;
  localparam logic [7:0] Lead3High = 8'hef;
  localparam logic [7:0] Lead4Low = 8'hf0;
  localparam logic [7:0] Lead4High = 8'hf4;
  localparam logic [7:0] ContMask = 8'hc0;
  localparam logic [7:0] ContPattern = 8'h80;

  localparam logic [20:0] MaxCodePoint = 21'h10ffff;
  localparam logic [20:0] SurrogateLow = 21'h00d800;
  localparam logic [20:0] SurrogateHigh = 21'h00dfff;
  localparam logic [20:0] SupplementaryBase = 21'h010000;
  localparam logic [15:0] HighSurrogateBase = 16'hd800;
  localparam logic [15:0] LowSurrogateBase = 16'hdc00;
  localparam logic [20:0] MinTwoByte = 21'h000080;
  localparam logic [20:0] MinThreeByte = 21'h000800;
  localparam logic [20:0] MinFourByte = 21'h010000;

  // Body of one job: what the byte of the item expands into.
  typedef enum logic [2:0] {
    BODY_NONE,
    BODY_CHAR,
    BODY_BSL,
    BODY_U1,
    BODY_U2
  } body_kind_t;

  // What closes a job, after the body.
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_QUOTE,
    TAIL_INVALID,
    TAIL_LIMIT
  } tail_kind_t;

  typedef struct packed {
    logic open_q;
    body_kind_t body;
    logic [6:0] ch;
    logic [15:0] val1;
    logic [15:0] val2;
    tail_kind_t tail;
  } job_t;

  function automatic logic [StepWidth-1:0] body_len(input body_kind_t kind);
    logic [StepWidth-1:0] len;
    unique case (kind)
      BODY_NONE: len = StepWidth'(0);
      BODY_CHAR: len = StepWidth'(1);
      BODY_BSL: len = StepWidth'(2);
      BODY_U1: len = StepWidth'(6);
      BODY_U2: len = StepWidth'(12);
      default: len = StepWidth'(0);
    endcase
    return len;
  endfunction

  function automatic logic [StepWidth-1:0] job_len(input job_t job);
    return StepWidth'(job.open_q) + body_len(job.body) +
           StepWidth'(job.tail != TAIL_NONE);
  endfunction

  // Adds a small increment and holds at the all-ones value.
  function automatic logic [CountWidth-1:0] sat_add(input logic [CountWidth-1:0] count,
                                                    input logic [StepWidth-1:0] inc);
    logic [CountWidth:0] sum;
    sum = {1'b0, count} + (CountWidth + 1)'(inc);
    return sum[CountWidth] ? {CountWidth{1'b1}} : sum[CountWidth-1:0];
  endfunction

  // Lowercase hex digit.
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? 7'(7'h30 + 7'(nib)) : 7'(7'h57 + 7'(nib));
  endfunction

endpackage

FILE: sv/u8je_front.sv
// Front end: takes input beats, decodes UTF-8, runs the limit checks and queues jobs.
module u8je_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] text_byte,
  input  logic first_of_string,
  input  logic last_of_string,
  input  logic has_byte,
  input  logic cfg_write_enable,
  input  logic [u8je_pkg::CfgWidth-1:0] cfg_write_data,
  input  logic q_full,
  output logic push,
  output u8je_pkg::job_t push_job
);

  logic [u8je_pkg::CfgWidth-1:0] max_output_bytes;
  logic [u8je_pkg::CountWidth-1:0] output_count, count_next, cnt_a, cnt_b;
  logic [20:0] code_point_acc, acc_next, acc_b, acc_c, cp;
  logic [19:0] cp_off;
  logic [1:0] pending_continuations, pend_next, pend_b, pend_c;
  logic [1:0] sequence_class, cls_next, cls_b, cls_c;
  logic failed_flag, failed_next;
  logic live, accept, min_ok, hit_a, hit_b, byte_err, byte_err_limit;
  u8je_pkg::job_t job;

  assign accept = in_valid && !q_full;
  assign in_stall = q_full;

  always_comb begin
    live = first_of_string || !failed_flag;
    if (first_of_string) begin
      cnt_a = u8je_pkg::CountWidth'(1);
      pend_b = 2'd0;
      acc_b = '0;
      cls_b = 2'd0;
    end else begin
      cnt_a = output_count;
      pend_b = pending_continuations;
      acc_b = code_point_acc;
      cls_b = sequence_class;
    end
    hit_a = u8je_pkg::CmpWidth'(cnt_a) >= u8je_pkg::CmpWidth'(max_output_bytes);

    cp = {acc_b[14:0], text_byte[5:0]};
    cp_off = 20'(cp - u8je_pkg::SupplementaryBase);
    case (cls_b)
      2'd1: min_ok = cp >= u8je_pkg::MinTwoByte;
      2'd2: min_ok = cp >= u8je_pkg::MinThreeByte;
      2'd3: min_ok = cp >= u8je_pkg::MinFourByte;
      default: min_ok = 1'b1;
    endcase

    pend_c = pend_b;
    acc_c = acc_b;
    cls_c = cls_b;
    job.open_q = first_of_string;
    job.body = u8je_pkg::BODY_NONE;
    job.ch = '0;
    job.val1 = '0;
    job.val2 = '0;
    job.tail = u8je_pkg::TAIL_NONE;
    byte_err = 1'b0;
    byte_err_limit = 1'b0;

    if (has_byte) begin
      if (pend_b != 2'd0) begin
        if ((text_byte & u8je_pkg::ContMask) != u8je_pkg::ContPattern) begin
          byte_err = 1'b1;
        end else begin
          pend_c = pend_b - 2'd1;
          acc_c = cp;
          if (pend_b == 2'd1) begin
            acc_c = '0;
            cls_c = 2'd0;
            if (!min_ok || cp > u8je_pkg::MaxCodePoint ||
                (cp >= u8je_pkg::SurrogateLow && cp <= u8je_pkg::SurrogateHigh)) begin
              byte_err = 1'b1;
            end else if (cp[20:16] == 5'd0) begin
              job.body = u8je_pkg::BODY_U1;
              job.val1 = cp[15:0];
            end else begin
              job.body = u8je_pkg::BODY_U2;
              job.val1 = u8je_pkg::HighSurrogateBase | {6'd0, cp_off[19:10]};
              job.val2 = u8je_pkg::LowSurrogateBase | {6'd0, cp_off[9:0]};
            end
          end
        end
      end else if (hit_a) begin
        byte_err = 1'b1;
        byte_err_limit = 1'b1;
      end else if (!text_byte[7]) begin
        job.ch = text_byte[6:0];
        if (text_byte[6:0] == u8je_pkg::CharQuote || text_byte[6:0] == u8je_pkg::CharBackslash)
        begin
          job.body = u8je_pkg::BODY_BSL;
        end else if (text_byte[6:5] == 2'b00) begin
          job.body = u8je_pkg::BODY_U1;
          job.val1 = {8'd0, text_byte};
        end else begin
          job.body = u8je_pkg::BODY_CHAR;
        end
      end else begin
        unique case (text_byte) inside
          [u8je_pkg::Lead2Low:u8je_pkg::Lead2High]: begin
            acc_c = {16'd0, text_byte[4:0]};
            pend_c = 2'd1;
          end
          [u8je_pkg::Lead3Low:u8je_pkg::Lead3High]: begin
            acc_c = {17'd0, text_byte[3:0]};
            pend_c = 2'd2;
          end
          [u8je_pkg::Lead4Low:u8je_pkg::Lead4High]: begin
            acc_c = {18'd0, text_byte[2:0]};
            pend_c = 2'd3;
          end
          default: byte_err = 1'b1;
        endcase
        cls_c = pend_c;
      end
    end

    cnt_b = u8je_pkg::sat_add(cnt_a, u8je_pkg::body_len(job.body));
    hit_b = u8je_pkg::CmpWidth'(cnt_b) >= u8je_pkg::CmpWidth'(max_output_bytes);

    if (byte_err) begin
      job.tail = byte_err_limit ? u8je_pkg::TAIL_LIMIT : u8je_pkg::TAIL_INVALID;
    end else if (last_of_string) begin
      if (pend_c != 2'd0) begin
        job.tail = u8je_pkg::TAIL_INVALID;
      end else if (hit_b) begin
        job.tail = u8je_pkg::TAIL_LIMIT;
      end else begin
        job.tail = u8je_pkg::TAIL_QUOTE;
      end
    end

    // Any closing result, good or bad, ends the string.
    failed_next = job.tail != u8je_pkg::TAIL_NONE;
    if (job.tail == u8je_pkg::TAIL_QUOTE) begin
      count_next = u8je_pkg::sat_add(cnt_b, u8je_pkg::StepWidth'(1));
    end else begin
      count_next = cnt_b;
    end
    if (job.tail == u8je_pkg::TAIL_INVALID || job.tail == u8je_pkg::TAIL_LIMIT) begin
      pend_next = 2'd0;
      acc_next = '0;
      cls_next = 2'd0;
    end else begin
      pend_next = pend_c;
      acc_next = acc_c;
      cls_next = cls_c;
    end

    push = accept && live && (u8je_pkg::job_len(job) != '0);
    push_job = job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_output_bytes <= u8je_pkg::LimitReset;
      output_count <= '0;
      code_point_acc <= '0;
      pending_continuations <= 2'd0;
      sequence_class <= 2'd0;
      failed_flag <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        max_output_bytes <= cfg_write_data;
      end
      if (accept && live) begin
        output_count <= count_next;
        code_point_acc <= acc_next;
        pending_continuations <= pend_next;
        sequence_class <= cls_next;
        failed_flag <= failed_next;
      end
    end
  end

endmodule

FILE: sv/u8je_queue.sv
// Short job queue between the front end and the character sequencer.
module u8je_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  u8je_pkg::job_t push_job,
  input  logic pop,
  output u8je_pkg::job_t head_job,
  output logic empty,
  output logic full
);

  u8je_pkg::job_t slots [u8je_pkg::QueueDepth];
  logic [u8je_pkg::QueuePtrWidth-1:0] wr_ptr, rd_ptr;
  logic [u8je_pkg::QueuePtrWidth:0] fill;

  assign empty = fill == '0;
  assign full = fill == (u8je_pkg::QueuePtrWidth + 1)'(u8je_pkg::QueueDepth);
  assign head_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: fill <= fill + 1'b1;
        2'b01: fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // The sequencer only pops a job that is there, and the front end never pushes into a full queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue pushed while full");

endmodule

FILE: sv/u8je_back.sv
// Back end: expands the head job into characters, one output beat per cycle while the output is not stalled.
module u8je_back (
  input  logic clk,
  input  logic rst,
  input  u8je_pkg::job_t head_job,
  input  logic empty,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output logic [6:0] out_char,
  output logic run_last,
  output logic string_done,
  output logic [1:0] status
);

  logic [u8je_pkg::StepWidth-1:0] step, step_next, pos, sub, blen, total;
  logic [15:0] esc_val;
  logic [3:0] nib;
  logic load, take, is_last;
  logic [6:0] char_next;
  logic done_next;
  logic [1:0] status_next;

  assign load = !out_valid || !out_stall;
  assign take = load && !empty;

  always_comb begin
    blen = u8je_pkg::body_len(head_job.body);
    total = u8je_pkg::job_len(head_job);
    is_last = step == total - 1'b1;
    pos = step - u8je_pkg::StepWidth'(head_job.open_q);
    // Position inside one \uXXXX escape; the second escape of a pair starts at six.
    if (pos >= u8je_pkg::StepWidth'(6)) begin
      sub = pos - u8je_pkg::StepWidth'(6);
      esc_val = head_job.val2;
    end else begin
      sub = pos;
      esc_val = head_job.val1;
    end
    case (sub)
      u8je_pkg::StepWidth'(2): nib = esc_val[15:12];
      u8je_pkg::StepWidth'(3): nib = esc_val[11:8];
      u8je_pkg::StepWidth'(4): nib = esc_val[7:4];
      default: nib = esc_val[3:0];
    endcase

    done_next = 1'b0;
    status_next = u8je_pkg::StatusOk;
    if (head_job.open_q && step == '0) begin
      char_next = u8je_pkg::CharQuote;
    end else if (pos < blen) begin
      case (head_job.body)
        u8je_pkg::BODY_CHAR: char_next = head_job.ch;
        u8je_pkg::BODY_BSL: char_next = (pos == '0) ? u8je_pkg::CharBackslash : head_job.ch;
        default: begin
          if (sub == '0) begin
            char_next = u8je_pkg::CharBackslash;
          end else if (sub == u8je_pkg::StepWidth'(1)) begin
            char_next = u8je_pkg::CharU;
          end else begin
            char_next = u8je_pkg::hex_char(nib);
          end
        end
      endcase
    end else begin
      done_next = 1'b1;
      case (head_job.tail)
        u8je_pkg::TAIL_QUOTE: char_next = u8je_pkg::CharQuote;
        u8je_pkg::TAIL_INVALID: begin
          char_next = u8je_pkg::CharNul;
          status_next = u8je_pkg::StatusInvalid;
        end
        default: begin
          char_next = u8je_pkg::CharNul;
          status_next = u8je_pkg::StatusLimit;
        end
      endcase
    end

    pop = take && is_last;
    step_next = pop ? '0 : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step <= '0;
    end else begin
      if (load) begin
        out_valid <= !empty;
      end
      if (take) begin
        step <= step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_char <= char_next;
      run_last <= is_last;
      string_done <= done_next;
      status <= status_next;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
      step < u8je_pkg::StepWidth'(u8je_pkg::MaxResults))
    else $error("sequencer step beyond the longest job");

endmodule

FILE: sv/utf8_to_json_ascii_escaper_top.sv
// Top level of the UTF-8 to pure-ASCII JSON string escaper.
// A result beat passes through the job queue and then the output register of the sequencer.
// Throughput: one input beat per cycle while the job queue is not full and each gives at most one
// character; an input beat that expands to k characters holds the character sequencer for k beats (up to fourteen).
// A four-entry job queue lets the input keep running while the sequencer works off an escape.
// Reset (rst, synchronous) empties the queue and output, clears the decoder, sets the limit to 2**24.
module utf8_to_json_ascii_escaper_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] text_byte,
  input  logic first_of_string,
  input  logic last_of_string,
  input  logic has_byte,
  input  logic cfg_write_enable,
  input  logic [24:0] cfg_write_data,
  output logic out_valid,
  input  logic out_stall,
  output logic [6:0] out_char,
  output logic run_last,
  output logic string_done,
  output logic [1:0] status
);

  // Jobs handed from the decoder to the sequencer. A job describes every character
  // that one input beat causes: an optional opening quote, the expanded byte, and an
  // optional closing quote or error beat.
  u8je_pkg::job_t push_job, head_job;
  logic push, pop, q_empty, q_full;

  // The front end owns all string state (output count, code point assembly, the
  // failed flag) and the limit register, so every check sees the count as it stands
  // after the earlier beats, independent of how far the output lags behind.
  u8je_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .text_byte        (text_byte),
    .first_of_string  (first_of_string),
    .last_of_string   (last_of_string),
    .has_byte         (has_byte),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .q_full           (q_full),
    .push             (push),
    .push_job         (push_job)
  );

  u8je_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  // The back end steps through the head job and loads its output register whenever
  // that register is empty or being taken, so it streams one beat per cycle while a job is queued.
  u8je_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_job    (head_job),
    .empty       (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .run_last    (run_last),
    .string_done (string_done),
    .status      (status)
  );

  // A closing quote or an error always ends the run of beats of its input beat.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
      out_valid && string_done |-> run_last)
    else $error("string end not on the last beat of its item");

  // An error beat carries no character and always closes the string.
  a_error_beat: assert property (@(posedge clk) disable iff (rst)
      out_valid && status != u8je_pkg::StatusOk |-> string_done && out_char == u8je_pkg::CharNul)
    else $error("malformed error beat");

endmodule

FILE: tb/tb_utf8_to_json_ascii_escaper_top.sv
// Self-checking testbench for the UTF-8 to ASCII JSON string escaper top level.
`timescale 1ns / 100ps

module tb_utf8_to_json_ascii_escaper_top;

  // One input beat: a raw text byte and its framing flags.
  typedef struct packed {
    logic [7:0] b;
    logic first;
    logic last;
    logic has;
  } text_beat_t;

  // One output beat, laid out in the order the fields are compared.
  typedef struct packed {
    logic [6:0] ch;
    logic last;
    logic done;
    logic [1:0] st;
  } json_beat_t;

  // Clock, reset and every block input start from known values.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] text_byte = 8'h00;
  logic first_of_string = 1'b0;
  logic last_of_string = 1'b0;
  logic has_byte = 1'b0;
  logic cfg_write_enable = 1'b0;
  logic [24:0] cfg_write_data = 25'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [6:0] out_char;
  logic run_last;
  logic string_done;
  logic [1:0] status;

  utf8_to_json_ascii_escaper_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .text_byte(text_byte),
    .first_of_string(first_of_string),
    .last_of_string(last_of_string),
    .has_byte(has_byte),
    .cfg_write_enable(cfg_write_enable),
    .cfg_write_data(cfg_write_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char(out_char),
    .run_last(run_last),
    .string_done(string_done),
    .status(status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Beats waiting to be driven, and characters the escaper still owes us.
  text_beat_t bytes_to_send[$];
  json_beat_t expected_chars[$];
  json_beat_t item_chars[$];
  logic [7:0] text_buf[$];
  int content_beats = 0;
  int mismatches = 0;

  // Shadow copy of the escaper state, kept in step with every accepted beat.
  logic [24:0] limit_reg = u8je_pkg::LimitReset;
  logic [24:0] out_count = '0;
  logic [20:0] cp_acc = '0;
  logic [1:0] cont_left = '0;
  logic [1:0] seq_len = '0;
  bit string_closed = 1'b0;
  string hex_digits = "0123456789abcdef";

  // Handshake bookkeeping shared between the clock edges.
  logic in_taken = 1'b0;
  int gap_left = 0;
  int in_calm = 0;
  int stall_left = 0;
  int out_calm = 0;

  // ---------------------------------------------------------------------------
  // Escaper prediction
  // ---------------------------------------------------------------------------

  // A normal character; the count saturates at its all-ones value.
  task automatic emit_char(input logic [6:0] c);
    item_chars.push_back({c, 1'b0, 1'b0, u8je_pkg::StatusOk});
    if (out_count != '1) out_count = out_count + 1'b1;
  endtask

  // Six characters: backslash, 'u' and four lowercase hex digits.
  task automatic emit_u_escape(input logic [15:0] v);
    logic [15:0] shifted;
    byte d;
    emit_char(u8je_pkg::CharBackslash);
    emit_char(u8je_pkg::CharU);
    for (int sh = 12; sh >= 0; sh -= 4) begin
      shifted = v >> sh;
      d = hex_digits[shifted[3:0]];
      emit_char(d[6:0]);
    end
  endtask

  // An error beat ends the string and drops any half-built sequence.
  task automatic flag_error(input logic [1:0] st);
    item_chars.push_back({u8je_pkg::CharNul, 1'b0, 1'b1, st});
    string_closed = 1'b1;
    cont_left = '0;
    seq_len = '0;
    cp_acc = '0;
  endtask

  task automatic take_text_byte(input logic [7:0] b, output bit ok);
    logic [20:0] cp;
    logic [20:0] floor_cp;
    ok = 1'b1;
    if (cont_left != 0) begin
      // Inside a multi-byte sequence: only 10xxxxxx may follow.
      if ((b & u8je_pkg::ContMask) != u8je_pkg::ContPattern) begin
        flag_error(u8je_pkg::StatusInvalid);
        ok = 1'b0;
      end else begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 1'b1;
        if (cont_left == 0) begin
          cp = cp_acc;
          case (seq_len)
            2'd1: floor_cp = u8je_pkg::MinTwoByte;
            2'd2: floor_cp = u8je_pkg::MinThreeByte;
            2'd3: floor_cp = u8je_pkg::MinFourByte;
            default: floor_cp = '0;
          endcase
          seq_len = '0;
          cp_acc = '0;
          // Overlong forms, values past the Unicode range and surrogates are rejected.
          if (cp < floor_cp || cp > u8je_pkg::MaxCodePoint ||
              (cp >= u8je_pkg::SurrogateLow && cp <= u8je_pkg::SurrogateHigh)) begin
            flag_error(u8je_pkg::StatusInvalid);
            ok = 1'b0;
          end else if (cp <= 21'h00ffff) begin
            emit_u_escape(cp[15:0]);
          end else begin
            cp = cp - u8je_pkg::SupplementaryBase;
            emit_u_escape(u8je_pkg::HighSurrogateBase + {6'd0, cp[19:10]});
            emit_u_escape(u8je_pkg::LowSurrogateBase + {6'd0, cp[9:0]});
          end
        end
      end
    end else if (out_count >= limit_reg) begin
      // The length check comes ahead of looking at the lead byte at all.
      flag_error(u8je_pkg::StatusLimit);
      ok = 1'b0;
    end else if (b < 8'h80) begin
      if (b[6:0] == u8je_pkg::CharQuote || b[6:0] == u8je_pkg::CharBackslash) begin
        emit_char(u8je_pkg::CharBackslash);
        emit_char(b[6:0]);
      end else if (b < 8'h20) begin
        emit_u_escape({8'h00, b});
      end else begin
        emit_char(b[6:0]);
      end
    end else if (b >= u8je_pkg::Lead2Low && b <= u8je_pkg::Lead2High) begin
      cp_acc = {16'd0, b[4:0]};
      cont_left = 2'd1;
      seq_len = 2'd1;
    end else if (b >= u8je_pkg::Lead3Low && b <= u8je_pkg::Lead3High) begin
      cp_acc = {17'd0, b[3:0]};
      cont_left = 2'd2;
      seq_len = 2'd2;
    end else if (b >= u8je_pkg::Lead4Low && b <= u8je_pkg::Lead4High) begin
      cp_acc = {18'd0, b[2:0]};
      cont_left = 2'd3;
      seq_len = 2'd3;
    end else begin
      flag_error(u8je_pkg::StatusInvalid);
      ok = 1'b0;
    end
  endtask

  // Works out every character one accepted beat produces and queues them.
  task automatic escape_text_beat(input text_beat_t tb_in);
    bit ok;
    json_beat_t tail_beat;
    item_chars.delete();
    ok = 1'b1;
    if (tb_in.first) begin
      out_count = '0;
      cp_acc = '0;
      cont_left = '0;
      seq_len = '0;
      string_closed = 1'b0;
      emit_char(u8je_pkg::CharQuote);
    end
    // Once a string has ended, beats without a new opening are dropped silently.
    if (tb_in.first || !string_closed) begin
      if (tb_in.has) take_text_byte(tb_in.b, ok);
      if (ok && tb_in.last) begin
        if (cont_left != 0) begin
          flag_error(u8je_pkg::StatusInvalid);
        end else if (out_count >= limit_reg) begin
          flag_error(u8je_pkg::StatusLimit);
        end else begin
          item_chars.push_back({u8je_pkg::CharQuote, 1'b0, 1'b1, u8je_pkg::StatusOk});
          if (out_count != '1) out_count = out_count + 1'b1;
          string_closed = 1'b1;
        end
      end
      if (item_chars.size() != 0) begin
        tail_beat = item_chars.pop_back();
        tail_beat.last = 1'b1;
        item_chars.push_back(tail_beat);
      end
      foreach (item_chars[i]) expected_chars.push_back(item_chars[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking and prediction at the rising edge
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string why, input json_beat_t want,
                                 input json_beat_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns %s: expected char=%h run_last=%b done=%b status=%0d, %s%h%s%b%s%b%s%0d",
               $time, why, want.ch, want.last, want.done, want.st,
               "got char=", got.ch, " run_last=", got.last, " done=", got.done,
               " status=", got.st);
  endtask

  // The output is checked before the input is predicted, so an item accepted in
  // this cycle can never be confused with a result that leaves in this cycle.
  always @(posedge clk) begin : score_beats
    json_beat_t seen;
    json_beat_t want;
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      seen = {out_char, run_last, string_done, status};
      if (expected_chars.size() == 0) begin
        report_mismatch("result beat with nothing expected", '0, seen);
      end else begin
        want = expected_chars.pop_front();
        if (seen.ch !== want.ch || seen.last !== want.last ||
            seen.done !== want.done || seen.st !== want.st)
          report_mismatch("result beat mismatch", want, seen);
      end
    end
    if (!rst && in_valid && !in_stall)
      escape_text_beat({text_byte, first_of_string, last_of_string, has_byte});
  end

  // ---------------------------------------------------------------------------
  // Driving at the falling edge
  // ---------------------------------------------------------------------------

  // Most pauses are drawn from the short range; now and then one from the long range drags on.
  function automatic int pick_pause();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  // The input side moves to the next beat only once the current one was taken,
  // so a stalled beat keeps its payload. Calm stretches send back to back.
  always @(negedge clk) begin : drive_text
    text_beat_t nxt;
    if (in_calm > 0) in_calm <= in_calm - 1;
    else if ($urandom_range(0, 299) == 0) in_calm <= $urandom_range(50, 200);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (bytes_to_send.size() != 0) begin
        nxt = bytes_to_send.pop_front();
        text_byte <= nxt.b;
        first_of_string <= nxt.first;
        last_of_string <= nxt.last;
        has_byte <= nxt.has;
        in_valid <= 1'b1;
        gap_left <= (in_calm > 0 || $urandom_range(0, 1) == 0) ? 0 : pick_pause();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The output side holds off the escaper in bursts of random length.
  always @(negedge clk) begin
    if (out_calm > 0) out_calm <= out_calm - 1;
    else if ($urandom_range(0, 299) == 0) out_calm <= $urandom_range(50, 200);
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (out_calm == 0 && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_pause() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic add_beat(input logic [7:0] b, input bit first, input bit last, input bit has);
    bytes_to_send.push_back({b, first, last, has});
  endtask

  function automatic logic [7:0] rand_cont();
    return 8'($urandom_range(8'h80, 8'hbf));
  endfunction

  // Shortest UTF-8 encoding of a code point, appended to the text buffer.
  task automatic put_code_point(input logic [20:0] c);
    if (c < 21'h80) begin
      text_buf.push_back(c[7:0]);
    end else if (c < 21'h800) begin
      text_buf.push_back({3'b110, c[10:6]});
      text_buf.push_back({2'b10, c[5:0]});
    end else if (c < 21'h10000) begin
      text_buf.push_back({4'b1110, c[15:12]});
      text_buf.push_back({2'b10, c[11:6]});
      text_buf.push_back({2'b10, c[5:0]});
    end else begin
      text_buf.push_back({5'b11110, c[20:18]});
      text_buf.push_back({2'b10, c[17:12]});
      text_buf.push_back({2'b10, c[11:6]});
      text_buf.push_back({2'b10, c[5:0]});
    end
  endtask

  // Fills the text buffer with a short string. Clean strings are well-formed
  // UTF-8; the others have broken characters mixed in.
  task automatic build_text(input bit clean);
    int len;
    int pick;
    logic [20:0] c;
    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
    repeat (len) begin
      pick = $urandom_range(0, 99);
      if (!clean && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 7))
          0: text_buf.push_back(8'($urandom_range(0, 255)));
          1: text_buf.push_back(rand_cont());
          2: begin
            // Lead bytes that can never start a sequence.
            if ($urandom_range(0, 1) == 0) text_buf.push_back(8'($urandom_range(8'hc0, 8'hc1)));
            else text_buf.push_back(8'($urandom_range(8'hf5, 8'hff)));
            text_buf.push_back(rand_cont());
          end
          3: begin
            // Overlong forms of the three sequence lengths.
            case ($urandom_range(0, 2))
              0: text_buf.push_back(8'hc1);
              1: begin
                text_buf.push_back(8'he0);
                text_buf.push_back(8'($urandom_range(8'h80, 8'h9f)));
              end
              default: begin
                text_buf.push_back(8'hf0);
                text_buf.push_back(8'($urandom_range(8'h80, 8'h8f)));
                text_buf.push_back(rand_cont());
              end
            endcase
            text_buf.push_back(rand_cont());
          end
          4: begin
            text_buf.push_back(8'hed);
            text_buf.push_back(8'($urandom_range(8'ha0, 8'hbf)));
            text_buf.push_back(rand_cont());
          end
          5: begin
            text_buf.push_back(8'hf4);
            text_buf.push_back(8'($urandom_range(8'h90, 8'hbf)));
            text_buf.push_back(rand_cont());
            text_buf.push_back(rand_cont());
          end
          6: begin
            // A sequence cut short by one to three bytes.
            put_code_point(21'($urandom_range(21'h10000, 21'h10ffff)));
            repeat ($urandom_range(1, 3)) void'(text_buf.pop_back());
          end
          default: begin
            // A continuation slot filled with ASCII or another lead byte.
            text_buf.push_back(8'($urandom_range(8'hc2, 8'hef)));
            if ($urandom_range(0, 1) == 0) text_buf.push_back(8'($urandom_range(0, 8'h7f)));
            else text_buf.push_back(8'($urandom_range(8'hc0, 8'hff)));
          end
        endcase
      end else if (pick < 45) begin
        case ($urandom_range(0, 9))
          0: text_buf.push_back({1'b0, u8je_pkg::CharQuote});
          1: text_buf.push_back({1'b0, u8je_pkg::CharBackslash});
          2, 3: text_buf.push_back(8'($urandom_range(0, 8'h1f)));
          4: text_buf.push_back(8'h7f);
          default: text_buf.push_back(8'($urandom_range(8'h20, 8'h7e)));
        endcase
      end else if (pick < 65) begin
        put_code_point(21'($urandom_range(21'h80, 21'h7ff)));
      end else if (pick < 82) begin
        // Three-byte range with the surrogate block skipped over.
        c = 21'($urandom_range(21'h800, 21'hf7ff));
        if (c >= u8je_pkg::SurrogateLow) c = c + 21'h800;
        put_code_point(c);
      end else begin
        put_code_point(21'($urandom_range(21'h10000, 21'h10ffff)));
      end
    end
  endtask

  // Turns the text buffer into beats. Most strings close on their last byte;
  // some close on a separate empty beat and a few are left open. Empty beats
  // and stray bytes after the close are sprinkled in.
  task automatic send_text(input bit open);
    int n;
    int close_kind;
    n = text_buf.size();
    close_kind = $urandom_range(0, 19);
    if (n == 0) begin
      add_beat(8'($urandom_range(0, 255)), open, 1'b1, 1'b0);
    end else begin
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 24) == 0)
          add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
        add_beat(text_buf[i], open && i == 0, close_kind >= 5 && i == n - 1, 1'b1);
        content_beats++;
      end
      if (close_kind >= 2 && close_kind <= 4)
        add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
    end
    if ($urandom_range(0, 14) == 0) add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
    text_buf.delete();
  endtask

  // Waits until every beat went in and every character came out, then gives
  // the escaper time to finish any beat that produced nothing.
  task automatic wait_for_drain();
    @(posedge clk);
    #1;
    while (bytes_to_send.size() != 0 || in_valid || expected_chars.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (20) @(posedge clk);
  endtask

  // Only called with the escaper idle; the shadow limit follows the write.
  task automatic write_limit(input logic [24:0] v);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    limit_reg = v;
    @(posedge clk);
    #1;
  endtask

  initial begin
    int phase_goal;
    logic [24:0] lim;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset limit. The very first beat has no opening
    // quote, so it belongs to a string that was never opened.
    add_beat(8'h41, 1'b0, 1'b0, 1'b1);
    add_beat(8'h00, 1'b0, 1'b0, 1'b0);              // empty beat, nothing out
    add_beat({1'b0, u8je_pkg::CharQuote}, 1'b1, 1'b0, 1'b1);
    add_beat({1'b0, u8je_pkg::CharBackslash}, 1'b0, 1'b0, 1'b1);
    add_beat(8'h00, 1'b0, 1'b0, 1'b1);
    add_beat(8'h1f, 1'b0, 1'b0, 1'b1);
    add_beat(8'h7f, 1'b0, 1'b0, 1'b1);
    // Largest code point, which needs a surrogate pair, then the close.
    add_beat(8'hf4, 1'b0, 1'b0, 1'b1);
    add_beat(8'h8f, 1'b0, 1'b0, 1'b1);
    add_beat(8'hbf, 1'b0, 1'b0, 1'b1);
    add_beat(8'hbf, 1'b0, 1'b1, 1'b1);
    add_beat(8'h20, 1'b0, 1'b0, 1'b1);              // stray beat after the close
    add_beat(8'hff, 1'b1, 1'b1, 1'b0);              // empty string
    add_beat(8'h7e, 1'b1, 1'b1, 1'b1);              // one-byte string
    add_beat(8'hc0, 1'b1, 1'b0, 1'b1);              // lead byte that is never valid
    add_beat(8'h41, 1'b0, 1'b1, 1'b1);              // dropped after the error
    add_beat(8'hf5, 1'b1, 1'b1, 1'b1);
    add_beat(8'he0, 1'b1, 1'b0, 1'b1);              // overlong three-byte form
    add_beat(8'h80, 1'b0, 1'b0, 1'b1);
    add_beat(8'h80, 1'b0, 1'b0, 1'b1);
    add_beat(8'hed, 1'b1, 1'b0, 1'b1);              // encoded surrogate
    add_beat(8'ha0, 1'b0, 1'b0, 1'b1);
    add_beat(8'h80, 1'b0, 1'b0, 1'b1);
    add_beat(8'hf4, 1'b1, 1'b0, 1'b1);              // beyond the Unicode range
    add_beat(8'h90, 1'b0, 1'b0, 1'b1);
    add_beat(8'h80, 1'b0, 1'b0, 1'b1);
    add_beat(8'h80, 1'b0, 1'b0, 1'b1);
    add_beat(8'hc2, 1'b1, 1'b0, 1'b1);              // ASCII where a continuation belongs
    add_beat(8'h41, 1'b0, 1'b0, 1'b1);
    add_beat(8'hc2, 1'b1, 1'b1, 1'b1);              // string ends inside a sequence
    wait_for_drain();

    // A zero limit fails the very first check.
    write_limit(25'd0);
    add_beat(8'h41, 1'b1, 1'b0, 1'b1);
    wait_for_drain();
    // With a limit of one the opening quote alone uses it up.
    write_limit(25'd1);
    add_beat(8'h00, 1'b1, 1'b1, 1'b0);
    wait_for_drain();
    // The limit is reached exactly before the closing quote.
    write_limit(25'd3);
    add_beat(8'h41, 1'b1, 1'b0, 1'b1);
    add_beat(8'h42, 1'b0, 1'b1, 1'b1);
    wait_for_drain();
    // An escape runs past the limit; only the closing check catches it.
    write_limit(25'd4);
    add_beat(8'hc2, 1'b1, 1'b0, 1'b1);
    add_beat(8'h80, 1'b0, 1'b1, 1'b1);
    wait_for_drain();

    // Random part, one limit setting per phase, the extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: lim = 25'h1ffffff;
        1: lim = 25'($urandom_range(8, 40));
        2: lim = u8je_pkg::LimitReset;
        3: lim = 25'd1;
        4: lim = 25'($urandom_range(2, 12));
        default: lim = 25'($urandom_range(40, 120));
      endcase
      write_limit(lim);
      phase_goal = content_beats + 64;
      while (content_beats < phase_goal) begin
        build_text($urandom_range(0, 3) != 0);
        send_text($urandom_range(0, 24) != 0);
      end
      wait_for_drain();
    end

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Safety net well beyond the slowest legal run.
  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
